FILE: src/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg: shared types and constants for the postfix evaluator
// Operator codes, error codes, arithmetic unit op codes and interfaces.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int DATA_W          = 32;
  localparam int CNT_W           = $clog2(DATA_W + 1);
  localparam int STACK_DEPTH_DEF = 64;

  // ASCII operator characters
  localparam logic [7:0] CHAR_ADD = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_SUB = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_MUL = 8'h2A;  // '*'
  localparam logic [7:0] CHAR_DIV = 8'h2F;  // '/'

  // error codes, first one in an expression is kept
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_UNDERFLOW = 3'd1;
  localparam logic [2:0] ERR_DIVZERO   = 3'd2;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

  typedef logic [1:0] alu_op_t;
  localparam alu_op_t ALU_ADD = 2'd0;
  localparam alu_op_t ALU_SUB = 2'd1;
  localparam alu_op_t ALU_MUL = 2'd2;
  localparam alu_op_t ALU_DIV = 2'd3;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

  function automatic logic op_known(input logic [7:0] ch);
    logic k;
    case (ch)
      CHAR_ADD, CHAR_SUB, CHAR_MUL, CHAR_DIV: k = 1'b1;
      default:                                k = 1'b0;
    endcase
    return k;
  endfunction

  function automatic alu_op_t op_decode(input logic [7:0] ch);
    alu_op_t o;
    case (ch)
      CHAR_SUB: o = ALU_SUB;
      CHAR_MUL: o = ALU_MUL;
      CHAR_DIV: o = ALU_DIV;
      default:  o = ALU_ADD;
    endcase
    return o;
  endfunction

endpackage

FILE: src/rpn_stack.sv
// ----------------------------------------------------------------------------
// rpn_stack: operand stack storage
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module rpn_stack #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
  parameter int AW          = $clog2(STACK_DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [rpn_pkg::DATA_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [rpn_pkg::DATA_W-1:0] rd_data
);

  logic [rpn_pkg::DATA_W-1:0] mem [STACK_DEPTH];
  logic [rpn_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/rpn_alu.sv
// ----------------------------------------------------------------------------
// rpn_alu: shared arithmetic unit
// Add/sub registered on start; multiply by shift-add and divide by restoring
// division, one bit per cycle over DATA_W bits; divide ends with a sign fix.
// ----------------------------------------------------------------------------
module rpn_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  rpn_pkg::alu_req_t req,
  output rpn_pkg::alu_rsp_t rsp
);

  localparam int W = rpn_pkg::DATA_W;

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [rpn_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  rpn_pkg::alu_op_t           op_r, op_nxt;
  logic                       neg_r, neg_nxt;
  logic [W-1:0]               acc_r, acc_nxt;   // product or partial remainder
  logic [W-1:0]               x_r, x_nxt;       // multiplicand or divisor
  logic [W-1:0]               y_r, y_nxt;       // multiplier or dividend/quotient
  logic [W-1:0]               res_r, res_nxt;
  logic [W-1:0]               mag_l, mag_r;
  logic [W:0]                 rem_sh, rem_sub;

  always_comb begin
    mag_l = req.lhs[W-1] ? (W'(0) - req.lhs) : req.lhs;
    mag_r = req.rhs[W-1] ? (W'(0) - req.rhs) : req.rhs;
    rem_sh  = {acc_r, y_r[W-1]};
    rem_sub = rem_sh - {1'b0, x_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    op_nxt   = op_r;
    neg_nxt  = neg_r;
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    res_nxt  = res_r;
    if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        if (op_r == rpn_pkg::ALU_MUL) begin
          res_nxt = acc_r;
        end else begin
          res_nxt = neg_r ? (W'(0) - y_r) : y_r;
        end
      end else begin
        cnt_nxt = cnt_r - rpn_pkg::CNT_W'(1);
        if (op_r == rpn_pkg::ALU_MUL) begin
          if (y_r[0]) begin
            acc_nxt = acc_r + x_r;
          end
          x_nxt = {x_r[W-2:0], 1'b0};
          y_nxt = {1'b0, y_r[W-1:1]};
        end else begin
          if (!rem_sub[W]) begin
            acc_nxt = rem_sub[W-1:0];
            y_nxt   = {y_r[W-2:0], 1'b1};
          end else begin
            acc_nxt = rem_sh[W-1:0];
            y_nxt   = {y_r[W-2:0], 1'b0};
          end
        end
      end
    end else if (req.start) begin
      op_nxt = req.op;
      case (req.op)
        rpn_pkg::ALU_ADD: begin
          res_nxt  = req.lhs + req.rhs;
          done_nxt = 1'b1;
        end
        rpn_pkg::ALU_SUB: begin
          res_nxt  = req.lhs - req.rhs;
          done_nxt = 1'b1;
        end
        rpn_pkg::ALU_MUL: begin
          acc_nxt  = '0;
          x_nxt    = req.lhs;
          y_nxt    = req.rhs;
          cnt_nxt  = rpn_pkg::CNT_W'(W);
          busy_nxt = 1'b1;
        end
        default: begin
          if (req.rhs == '0) begin
            res_nxt  = '0;
            done_nxt = 1'b1;
          end else begin
            acc_nxt  = '0;
            x_nxt    = mag_r;
            y_nxt    = mag_l;
            neg_nxt  = req.lhs[W-1] ^ req.rhs[W-1];
            cnt_nxt  = rpn_pkg::CNT_W'(W);
            busy_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    op_r  <= op_nxt;
    neg_r <= neg_nxt;
    acc_r <= acc_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    res_r <= res_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule

FILE: src/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator: reverse Polish expression evaluator
// Operand stack in RAM, a token sequencer and one shared arithmetic unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one token per transfer. in_tuser = 1 marks a number
//   (in_tdata[39:8]), 0 an operator character (in_tdata[7:0]). in_tlast marks
//   the final token of an expression.
//   Output stream (out_*): one transfer per expression, after its last token:
//   out_tdata = top of stack, out_tuser = first error seen
//   (0 ok, 1 underflow, 2 divide by zero, 3 unknown operator, 4 overflow).
// Sequencing: one token at a time, in_tready low while it is worked on.
//   number / rejected operator : decode, tail
//   + or -, or / by zero       : decode, operand reads, start, unit result, tail
//   * or /                     : as above, with DATA_W shift steps and a
//                                final step (sign fix for /) in the shared unit
//   a last token also passes a top-of-stack read (skipped when the stack is
//   empty) to reach the output register, plus any wait for it to free.
// Reset empties the stack and clears the sticky error; stack RAM needs no
// clearing since no entry is read before being pushed.
// The output register holds a result until it is taken; further tokens are
// accepted meanwhile, and only a second result waits for the slot to free.
// ----------------------------------------------------------------------------
module postfix_expression_evaluator #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] operator_char, [39:8] operand_value
  input  logic        in_tuser,   // [0] is_number
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] result_value
  output logic [2:0]  out_tuser   // [2:0] error_status
);

  localparam int W    = rpn_pkg::DATA_W;
  localparam int AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SP_W = $clog2(STACK_DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_RD_L   = 3'd2;
  localparam logic [2:0] S_START  = 3'd3;
  localparam logic [2:0] S_ALU    = 3'd4;
  localparam logic [2:0] S_TAIL   = 3'd5;
  localparam logic [2:0] S_TOP    = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]      state_r, state_nxt;
  logic [SP_W-1:0] sp_r, sp_nxt;
  logic [2:0]      err_r, err_nxt;
  logic [W-1:0]    ropnd_r, ropnd_nxt;    // right operand
  logic [W-1:0]    res_r, res_nxt;        // value to emit
  logic            out_valid_r, out_valid_nxt;
  logic [W-1:0]    out_data_r, out_data_nxt;
  logic [2:0]      out_err_r, out_err_nxt;

  // latched token
  logic            tok_num_r;
  logic [7:0]      tok_op_r;
  logic [W-1:0]    tok_val_r;
  logic            tok_last_r;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [W-1:0]    mem_wdata, mem_rdata;
  logic [SP_W-1:0] sp_m1, sp_m2;
  logic            in_xfer, emit_go;

  rpn_pkg::alu_req_t alu_req;
  rpn_pkg::alu_rsp_t alu_rsp;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign sp_m1     = sp_r - SP_W'(1);
  assign sp_m2     = sp_r - SP_W'(2);
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    err_nxt       = err_r;
    ropnd_nxt     = ropnd_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_err_nxt   = out_err_r;
    mem_we        = 1'b0;
    mem_waddr     = sp_r[AW-1:0];
    mem_wdata     = tok_val_r;
    mem_raddr     = sp_m1[AW-1:0];
    alu_req.start = 1'b0;
    alu_req.op    = rpn_pkg::op_decode(tok_op_r);
    alu_req.lhs   = mem_rdata;
    alu_req.rhs   = ropnd_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_TAIL;
        if (tok_num_r) begin
          if (sp_r == SP_W'(STACK_DEPTH)) begin
            if (err_r == rpn_pkg::ERR_OK) err_nxt = rpn_pkg::ERR_OVERFLOW;
          end else begin
            mem_we = 1'b1;
            sp_nxt = sp_r + SP_W'(1);
          end
        end else if (!rpn_pkg::op_known(tok_op_r)) begin
          if (err_r == rpn_pkg::ERR_OK) err_nxt = rpn_pkg::ERR_UNKNOWN;
        end else if (sp_r < SP_W'(2)) begin
          if (err_r == rpn_pkg::ERR_OK) err_nxt = rpn_pkg::ERR_UNDERFLOW;
        end else begin
          state_nxt = S_RD_L;       // right operand read issued
        end
      end
      S_RD_L: begin
        ropnd_nxt = mem_rdata;
        mem_raddr = sp_m2[AW-1:0];
        state_nxt = S_START;
      end
      S_START: begin
        alu_req.start = 1'b1;
        if (alu_req.op == rpn_pkg::ALU_DIV && ropnd_r == '0 &&
            err_r == rpn_pkg::ERR_OK) begin
          err_nxt = rpn_pkg::ERR_DIVZERO;
        end
        state_nxt = S_ALU;
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          mem_we    = 1'b1;
          mem_waddr = sp_m2[AW-1:0];
          mem_wdata = alu_rsp.result;
          sp_nxt    = sp_m1;
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        if (!tok_last_r) begin
          state_nxt = S_IDLE;
        end else if (sp_r == '0) begin
          if (err_r == rpn_pkg::ERR_OK) err_nxt = rpn_pkg::ERR_UNDERFLOW;
          res_nxt   = '0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_TOP;        // top-of-stack read issued
        end
      end
      S_TOP: begin
        res_nxt   = mem_rdata;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          out_err_nxt   = err_r;
          sp_nxt        = '0;
          err_nxt       = rpn_pkg::ERR_OK;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      err_r       <= rpn_pkg::ERR_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ropnd_r    <= ropnd_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    out_err_r  <= out_err_nxt;
    if (in_xfer) begin
      tok_num_r  <= in_tuser;
      tok_op_r   <= in_tdata[7:0];
      tok_val_r  <= in_tdata[39:8];
      tok_last_r <= in_tlast;
    end
  end

  rpn_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .AW          (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  rpn_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

`ifndef ASSERT_OFF
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= rpn_pkg::ERR_OVERFLOW)
    else $error("bad error code on output");

  a_alu_done: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> state_r == S_ALU)
    else $error("arithmetic result outside wait state");

  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> (sp_r == '0 && err_r == rpn_pkg::ERR_OK && out_tvalid))
    else $error("expression state not cleared after result");
`endif

endmodule

FILE: dv/postfix_expression_evaluator_tb.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator_tb: self-checking bench for the RPN evaluator
// Streams postfix tokens into the block and checks every result transfer
// against an in-bench stack model. It runs directed corner expressions, one
// deep expression that overruns the stack, then random expressions (mostly
// well formed, some malformed). Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module postfix_expression_evaluator_tb;

  localparam int          STACK_DEPTH  = rpn_pkg::STACK_DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 800;     // long receiver hold-off
  localparam int unsigned DRAIN_CYCLES = 64;      // covers the slowest token and the output path

  // one expected result transfer
  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  status;
  } rpn_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: stack model of the evaluator plus the queue of results due
  // --------------------------------------------------------------------------
  class rpn_scoreboard;
    logic [31:0]  stack_mem [STACK_DEPTH];
    int unsigned  depth;
    logic [2:0]   first_err = rpn_pkg::ERR_OK;
    rpn_result_t  due_q [$];
    int unsigned  fail_count;

    function void flag(logic [2:0] code);
      if (first_err == rpn_pkg::ERR_OK) first_err = code;
    endfunction

    // an input transfer was accepted: advance the model, queue any result
    function void note_token(bit is_num, logic [7:0] ch, logic [31:0] val, bit last);
      logic [31:0] lhs, rhs, lmag, rmag, quo, res;
      rpn_result_t r;
      if (is_num) begin
        if (depth >= STACK_DEPTH) flag(rpn_pkg::ERR_OVERFLOW);  // number dropped
        else begin
          stack_mem[depth] = val;
          depth++;
        end
      end else if (!(ch == rpn_pkg::CHAR_ADD || ch == rpn_pkg::CHAR_SUB ||
                     ch == rpn_pkg::CHAR_MUL || ch == rpn_pkg::CHAR_DIV)) begin
        flag(rpn_pkg::ERR_UNKNOWN);  // stack untouched
      end else if (depth < 2) begin
        flag(rpn_pkg::ERR_UNDERFLOW);  // stack untouched
      end else begin
        rhs = stack_mem[depth-1];
        lhs = stack_mem[depth-2];
        case (ch)
          rpn_pkg::CHAR_ADD: res = lhs + rhs;
          rpn_pkg::CHAR_SUB: res = lhs - rhs;
          rpn_pkg::CHAR_MUL: res = lhs * rhs;
          default: begin
            if (rhs == '0) begin
              flag(rpn_pkg::ERR_DIVZERO);
              res = '0;
            end else begin
              // truncate toward zero on magnitudes; MIN / -1 wraps to MIN
              lmag = lhs[31] ? -lhs : lhs;
              rmag = rhs[31] ? -rhs : rhs;
              quo  = lmag / rmag;
              res  = (lhs[31] ^ rhs[31]) ? -quo : quo;
            end
          end
        endcase
        depth--;
        stack_mem[depth-1] = res;
      end
      if (last) begin
        if (depth == 0) begin
          flag(rpn_pkg::ERR_UNDERFLOW);
          r.value = '0;
        end else begin
          r.value = stack_mem[depth-1];
        end
        r.status = first_err;
        due_q.push_back(r);
        depth     = 0;
        first_err = rpn_pkg::ERR_OK;
      end
    endfunction

    // a result transfer was accepted: compare with the oldest one due
    function void check_result(logic [31:0] value, logic [2:0] status);
      rpn_result_t r;
      if (due_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR: result transfer with none due: value %h status %0d",
                   value, status);
      end else begin
        r = due_q.pop_front();
        if (value !== r.value || status !== r.status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: value exp %h got %h, status exp %0d got %0d",
                     r.value, value, r.status, status);
        end
      end
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block and its ports
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // [7:0] operator_char, [39:8] operand_value
  logic        in_tuser;   // [0] is_number
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] result_value
  logic [2:0]  out_tuser;  // [2:0] error_status

  postfix_expression_evaluator #(
    .STACK_DEPTH (STACK_DEPTH)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  rpn_scoreboard sb = new;

  int unsigned tx_idle_pct = 0;   // sender gap chance per cycle, in percent
  int unsigned rx_idle_pct = 0;   // receiver stall chance per cycle
  int unsigned token_count = 0;   // accepted input transfers
  int unsigned hold_seq    = 0;   // bumped by the stimulus to ask for a hold-off
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;
  int unsigned cycle_count = 0;

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Receiver: checks each result transfer, stalls at random; a hold-off
  // request holds tready low until hold_left runs down, so the block backs up.
  // Values read straight after the edge are the ones the block saw at it.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------

  // one token transfer; valid held high until accepted, random gaps before it
  task automatic send_token(bit is_num, logic [7:0] ch, logic [31:0] val, bit last);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= is_num;
    in_tdata  <= {val, ch};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_token(is_num, ch, val, last);
    token_count++;
  endtask

  // unused field bits are randomised so every tdata bit toggles either way
  task automatic push_num(logic [31:0] val, bit last);
    send_token(1'b1, 8'($urandom), val, last);
  endtask

  task automatic apply_op(logic [7:0] ch, bit last);
    send_token(1'b0, ch, $urandom, last);
  endtask

  // operands biased to extremes and small values (small ones find zero divisors)
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0;
      4, 5, 6: return 32'($signed($urandom_range(8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(3))
      0:       return rpn_pkg::CHAR_ADD;
      1:       return rpn_pkg::CHAR_SUB;
      2:       return rpn_pkg::CHAR_MUL;
      default: return rpn_pkg::CHAR_DIV;
    endcase
  endfunction

  // well-formed expression: operators only when two operands are held,
  // tlast on the token that leaves a single value
  task automatic send_expression(int unsigned operands);
    int unsigned held, left;
    bit          take_num, last;
    held = 0;
    left = operands;
    while (left != 0 || held > 1) begin
      take_num = (left != 0) && (held < 2 || $urandom_range(1) == 1);
      if (take_num) begin
        left--;
        held++;
      end else begin
        held--;
      end
      last = (left == 0 && held <= 1);
      if (take_num) push_num(pick_value(), last);
      else apply_op(pick_op(), last);
    end
  endtask

  // malformed: any mix of numbers, operators and arbitrary characters
  task automatic send_noise(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(2))
        0:       push_num(pick_value(), i == n - 1);
        1:       apply_op(pick_op(), i == n - 1);
        default: apply_op(8'($urandom), i == n - 1);
      endcase
    end
  endtask

  // deep: push up to or past the stack size, then fold down to one value
  task automatic send_deep(int unsigned pushes);
    int unsigned held;
    held = (pushes > STACK_DEPTH) ? STACK_DEPTH : pushes;
    for (int unsigned i = 0; i < pushes; i++) push_num(pick_value(), 1'b0);
    while (held > 1) begin
      held--;
      apply_op(pick_op(), held == 1);
    end
  endtask

  // sender stops until every result due has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned pick;
    bit          hold_done, pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners, light idling
    tx_idle_pct = 35;
    rx_idle_pct = 35;
    // most negative divided by minus one wraps
    push_num(32'h8000_0000, 1'b0); push_num(32'hFFFF_FFFF, 1'b0);
    apply_op(rpn_pkg::CHAR_DIV, 1'b1);
    // addition wraps at 32 bits
    push_num(32'h7FFF_FFFF, 1'b0); push_num(32'h1, 1'b0);
    apply_op(rpn_pkg::CHAR_ADD, 1'b1);
    // divide by zero pushes 0
    push_num(32'd7, 1'b0); push_num(32'h0, 1'b0); apply_op(rpn_pkg::CHAR_DIV, 1'b1);
    // too few operands: stack kept
    push_num(32'd5, 1'b0); apply_op(rpn_pkg::CHAR_ADD, 1'b1);
    // empty stack at the last token
    apply_op(rpn_pkg::CHAR_SUB, 1'b1);
    // unknown operator on an empty stack: first error kept
    apply_op(8'hFF, 1'b1);
    // multiply wraps
    push_num(32'h1234_5678, 1'b0); push_num(32'hFFFF_FFFD, 1'b0);
    apply_op(rpn_pkg::CHAR_MUL, 1'b1);
    // negative division truncates toward zero
    push_num(32'hFFFF_FFF9, 1'b0); push_num(32'd2, 1'b0);
    apply_op(rpn_pkg::CHAR_DIV, 1'b1);
    // unknown operator mid-expression, operand order of subtraction
    push_num(32'd10, 1'b0); push_num(32'd3, 1'b0); apply_op(8'h00, 1'b0);
    apply_op(rpn_pkg::CHAR_SUB, 1'b1);
    // single number with tlast
    push_num(32'h5555_AAAA, 1'b1);
    // full stack: extra numbers dropped, overflow flagged
    send_deep(STACK_DEPTH + 2);
    wait_drained();

    // random expressions; the opening stretch has no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    token_count = 0;
    while (token_count < RANDOM_ITEMS) begin
      if (token_count >= 250) begin
        tx_idle_pct = 35;
        rx_idle_pct = 35;
      end
      if (!hold_done && token_count >= 500) begin
        hold_seq++;          // receiver backs off while we keep offering
        hold_done = 1'b1;
      end
      if (!pause_done && token_count >= 800) begin
        wait_drained();
        pause_done = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 1) send_deep($urandom_range(STACK_DEPTH + 6, STACK_DEPTH - 4));
      else if (pick < 18) send_noise($urandom_range(6, 1));
      else if (pick < 22) send_expression($urandom_range(12, 7));
      else send_expression($urandom_range(6, 1));
    end
    in_tvalid <= 1'b0;

    // wait for what is due, then watch for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: postfix_expression_evaluator.f
src/rpn_pkg.sv
src/rpn_stack.sv
src/rpn_alu.sv
src/postfix_expression_evaluator.sv
dv/postfix_expression_evaluator_tb.sv
